FILE: src/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared widths, constants, status codes and the elaboration-time log table
// builder for the thermistor code to Fahrenheit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  // Field widths
  localparam int unsigned CODE_W   = 15;
  localparam int unsigned BETA_W   = 16;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Log table
  localparam int unsigned LN_DEPTH_DEF = 256;
  localparam int unsigned LN_W         = 24;   // Q24, entries up to ln(2)
  localparam int unsigned FRAC_W       = 16;   // mantissa fraction bits
  localparam int unsigned EXP_W        = 4;    // exponent of a 15-bit value
  localparam int unsigned LNSUM_W      = 28;   // ln of a 15-bit value, Q24

  // Inverse temperature path
  localparam int unsigned N1_W   = LNSUM_W + 24;  // |ln ratio| << 24
  localparam int unsigned TERM_W = 44;            // larger terms saturate
  localparam int unsigned INV_W  = TERM_W + 2;    // signed inverse temp, Q48
  localparam int unsigned U_W    = INV_W - 1;
  localparam int unsigned D2_W   = INV_W;         // 2*u
  localparam int unsigned N2_W   = 57;            // 360<<48 + u
  localparam int unsigned Q2_W   = 18;            // larger quotients saturate
  localparam int unsigned TMP_W  = Q2_W + 2;

  // Reset values of the registers
  localparam logic [BETA_W-1:0] BETA_RST = 16'd3428;
  localparam logic [CODE_W-1:0] FS_RST   = 15'd26000;

  // 1/298.15 in Q48, rounded
  localparam logic [63:0] INV_T0_64 = ((64'd100 << 48) + 64'd14907) / 64'd29815;
  localparam logic [INV_W-1:0] INV_T0 = INV_W'(INV_T0_64);
  // 180 * 2 * 2^48, numerator of the rounded reciprocal
  localparam logic [N2_W-1:0] NUM_360 = N2_W'(64'd360 << 48);

  // Output limits, hundredths of a degree
  localparam logic signed [TMP_W-1:0] TEMP_OFFSET = 20'sd45967;
  localparam logic signed [TMP_W-1:0] TEMP_MAX    = 20'sd60000;
  localparam logic signed [TMP_W-1:0] TEMP_MIN    = -20'sd40000;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  // Flags riding along the first divider
  typedef struct packed {
    logic oor;
    logic neg;
    logic ovf;
  } div1_side_t;

  // Flags riding along the second divider
  typedef struct packed {
    logic oor;
    logic sat_lo;
    logic sat_hi;
  } div2_side_t;

  // Shift-subtract division, used only to build constants
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/dep) in Q24 via 2*atanh(k/(2*dep+k))
  function automatic logic [LN_W-1:0] ln_entry(input int unsigned k, input int unsigned dep);
    logic [63:0] den;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] tmp;
    den = 64'(2 * dep + k);
    y   = (udiv64(64'(k) << 31, den) + 64'd1) >> 1;
    y2  = (y * y + (64'd1 << 29)) >> 30;
    p   = y;
    s   = '0;
    n   = 64'd1;
    for (int i = 0; i < 64; i++) begin
      if (p != 64'd0) begin
        s = s + udiv64(p, n);
        p = (p * y2) >> 30;
        n = n + 64'd2;
      end
    end
    tmp = (64'd2 * s + 64'd32) >> 6;
    return tmp[LN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/tcf_div_pipe.sv
// ----------------------------------------------------------------------------
// tcf_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num >> QW is below den; flags and valid travel with the data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_div_pipe #(
  parameter int unsigned NW = 52,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 44,
  parameter int unsigned SW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // Stage registers
  logic          v_q    [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  // Stage inputs and next values
  logic          v_in    [QW];
  logic [DW-1:0] rem_in  [QW];
  logic [QW-1:0] low_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [SW-1:0] side_in [QW];
  logic [DW-1:0] rem_d   [QW];
  logic [QW-1:0] quo_d   [QW];
  logic [DW:0]   rext;
  logic          ge;

  // Route each stage's inputs
  always_comb begin
    v_in[0]    = valid_i;
    rem_in[0]  = DW'(num_i[NW-1:QW]);
    low_in[0]  = num_i[QW-1:0];
    quo_in[0]  = '0;
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int s = 1; s < QW; s++) begin
      v_in[s]    = v_q[s-1];
      rem_in[s]  = rem_q[s-1];
      low_in[s]  = low_q[s-1] << 1;
      quo_in[s]  = quo_q[s-1];
      den_in[s]  = den_q[s-1];
      side_in[s] = side_q[s-1];
    end
  end

  // One compare and subtract per stage
  always_comb begin
    rext = '0;
    ge   = 1'b0;
    for (int s = 0; s < QW; s++) begin
      rext     = {rem_in[s], low_in[s][QW-1]};
      ge       = rext >= {1'b0, den_in[s]};
      rem_d[s] = ge ? DW'(rext - {1'b0, den_in[s]}) : rext[DW-1:0];
      quo_d[s] = {quo_in[s][QW-2:0], ge};
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < QW; s++) v_q[s] <= v_in[s];
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s]  <= rem_d[s];
        low_q[s]  <= low_in[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

FILE: src/thermistor_code_to_fahrenheit_core.sv
// ----------------------------------------------------------------------------
// thermistor_code_to_fahrenheit_core
// Converts a thermistor divider ADC code to hundredths of a degree F using
// the beta equation, with a table-based natural log and two divider pipes.
// ----------------------------------------------------------------------------
// The block takes one ADC code per cycle while in_ready_o is high and returns
// one result per code, in order. The datapath has 72 register stages: the
// two bit-per-stage divider pipelines (44 stages for ln(ratio)/beta, 18 stages
// for the final reciprocal) plus ten stages of log lookup, interpolation,
// formatting and the output buffer.
// A two-entry output buffer lets the pipeline keep taking requests while a
// result waits; the pipeline halts only when both entries are full.
// Registers: beta at 0x0, full_scale_code at 0x4; write them only while no
// request is in flight. Status 1 flags a code of 0 or at/above full scale,
// status 2 a result clamped to -400.00 .. 600.00 F.
`default_nettype none

module thermistor_code_to_fahrenheit_core #(
  parameter int unsigned LN_TABLE_DEPTH = tcf_pkg::LN_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0]          paddr,
  input  logic [tcf_pkg::DATA_W-1:0]          pwdata,
  output logic [tcf_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // Request
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tcf_pkg::CODE_W-1:0]          adc_code_i,
  // Result
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tcf_pkg::TEMP_W-1:0]   temp_centi_f_o,
  output logic [tcf_pkg::STATUS_W-1:0]        status_o
);

  import tcf_pkg::*;

  localparam int unsigned IDX_W = $clog2(LN_TABLE_DEPTH + 1);
  localparam int unsigned T_W   = FRAC_W + IDX_W;
  localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(LN_TABLE_DEPTH);

  // --------------------------------------------------------------------------
  // Log table, built at elaboration
  wire [LN_W-1:0] ln_tab [LN_TABLE_DEPTH+1];
  for (genvar k = 0; k <= LN_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [LN_W-1:0] ENT = ln_entry(k, LN_TABLE_DEPTH);
    assign ln_tab[k] = ENT;
  end

  // --------------------------------------------------------------------------
  // Registers
  logic [BETA_W-1:0] beta_q;
  logic [CODE_W-1:0] fs_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RST;
      fs_q   <= FS_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) fs_q <= pwdata[CODE_W-1:0];
      else          beta_q <= pwdata[BETA_W-1:0];
    end
  end

  assign prdata = paddr[2] ? DATA_W'(fs_q) : DATA_W'(beta_q);

  // Beta of zero acts as one
  logic [BETA_W-1:0] beta_eff;
  assign beta_eff = (beta_q == '0) ? BETA_W'(1) : beta_q;

  // --------------------------------------------------------------------------
  // Pipeline enable, held off only while the output buffer is full
  logic [1:0] ocnt_q;
  logic       en;
  assign en         = (ocnt_q != 2'd2);
  assign in_ready_o = en;

  // Leading one position of a code
  function automatic logic [EXP_W-1:0] lead_one(input logic [CODE_W-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (x[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // S1: range check, form both divider legs
  logic              s1_v_q, s1_oor_q;
  logic [CODE_W-1:0] s1_x1_q, s1_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_oor_q <= (adc_code_i == '0) || (adc_code_i >= fs_q);
      s1_x1_q  <= adc_code_i;
      s1_x2_q  <= fs_q - adc_code_i;
    end
  end

  // --------------------------------------------------------------------------
  // S2: normalize to 2^e * (1 + f/65536)
  logic                      s2_v_q, s2_oor_q;
  logic [EXP_W-1:0]          s2_e1_q, s2_e2_q, e1_d, e2_d;
  logic [FRAC_W-1:0]         s2_f1_q, s2_f2_q;
  logic [CODE_W+FRAC_W-1:0]  sh1_d, sh2_d;

  always_comb begin
    e1_d  = lead_one(s1_x1_q);
    e2_d  = lead_one(s1_x2_q);
    sh1_d = {s1_x1_q, {FRAC_W{1'b0}}} >> e1_d;
    sh2_d = {s1_x2_q, {FRAC_W{1'b0}}} >> e2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_oor_q <= s1_oor_q;
      s2_e1_q  <= e1_d;
      s2_e2_q  <= e2_d;
      s2_f1_q  <= sh1_d[FRAC_W-1:0];
      s2_f2_q  <= sh2_d[FRAC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // S3: table index, weight and neighbor entries
  logic              s3_v_q, s3_oor_q;
  logic [EXP_W-1:0]  s3_e1_q, s3_e2_q;
  logic [FRAC_W-1:0] s3_w1_q, s3_w2_q;
  logic [LN_W-1:0]   s3_lo1_q, s3_lo2_q, s3_dl1_q, s3_dl2_q;
  logic [T_W-1:0]    t1_d, t2_d;
  logic [IDX_W-1:0]  i1_d, i2_d;

  always_comb begin
    t1_d = T_W'(s2_f1_q) * T_W'(DEPTH_C);
    t2_d = T_W'(s2_f2_q) * T_W'(DEPTH_C);
    i1_d = t1_d[T_W-1:FRAC_W];
    i2_d = t2_d[T_W-1:FRAC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_oor_q <= s2_oor_q;
      s3_e1_q  <= s2_e1_q;
      s3_e2_q  <= s2_e2_q;
      s3_w1_q  <= t1_d[FRAC_W-1:0];
      s3_w2_q  <= t2_d[FRAC_W-1:0];
      s3_lo1_q <= ln_tab[i1_d];
      s3_lo2_q <= ln_tab[i2_d];
      s3_dl1_q <= ln_tab[i1_d + IDX_W'(1)] - ln_tab[i1_d];
      s3_dl2_q <= ln_tab[i2_d + IDX_W'(1)] - ln_tab[i2_d];
    end
  end

  // --------------------------------------------------------------------------
  // S4: interpolation products
  logic                     s4_v_q, s4_oor_q;
  logic [EXP_W-1:0]         s4_e1_q, s4_e2_q;
  logic [LN_W-1:0]          s4_lo1_q, s4_lo2_q;
  logic [LN_W+FRAC_W-1:0]   s4_p1_q, s4_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_oor_q <= s3_oor_q;
      s4_e1_q  <= s3_e1_q;
      s4_e2_q  <= s3_e2_q;
      s4_lo1_q <= s3_lo1_q;
      s4_lo2_q <= s3_lo2_q;
      s4_p1_q  <= (LN_W+FRAC_W)'(s3_dl1_q) * (LN_W+FRAC_W)'(s3_w1_q);
      s4_p2_q  <= (LN_W+FRAC_W)'(s3_dl2_q) * (LN_W+FRAC_W)'(s3_w2_q);
    end
  end

  // --------------------------------------------------------------------------
  // S5: ln = e*ln2 + lo + rounded interpolation
  logic                     s5_v_q, s5_oor_q;
  logic [LNSUM_W-1:0]       s5_ln1_q, s5_ln2_q, ln1_d, ln2_d;
  logic [LN_W+FRAC_W:0]     r1_d, r2_d;

  always_comb begin
    r1_d  = (LN_W+FRAC_W+1)'(s4_p1_q) + (LN_W+FRAC_W+1)'(32768);
    r2_d  = (LN_W+FRAC_W+1)'(s4_p2_q) + (LN_W+FRAC_W+1)'(32768);
    ln1_d = LNSUM_W'(s4_e1_q) * LNSUM_W'(ln_tab[LN_TABLE_DEPTH]) + LNSUM_W'(s4_lo1_q)
          + LNSUM_W'(r1_d >> FRAC_W);
    ln2_d = LNSUM_W'(s4_e2_q) * LNSUM_W'(ln_tab[LN_TABLE_DEPTH]) + LNSUM_W'(s4_lo2_q)
          + LNSUM_W'(r2_d >> FRAC_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_oor_q <= s4_oor_q;
      s5_ln1_q <= ln1_d;
      s5_ln2_q <= ln2_d;
    end
  end

  // --------------------------------------------------------------------------
  // S6: log ratio as sign and magnitude
  logic               s6_v_q, s6_oor_q, s6_neg_q;
  logic [LNSUM_W-1:0] s6_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_oor_q <= s5_oor_q;
      s6_neg_q <= s5_ln1_q < s5_ln2_q;
      s6_mag_q <= (s5_ln1_q < s5_ln2_q) ? (s5_ln2_q - s5_ln1_q) : (s5_ln1_q - s5_ln2_q);
    end
  end

  // --------------------------------------------------------------------------
  // S7: dividend for (mag<<24 + beta/2) / beta, overflow precheck
  logic              s7_v_q;
  logic [N1_W-1:0]   s7_n1_q, n1_d;
  logic [BETA_W-1:0] s7_b_q;
  div1_side_t        s7_side_q, side1_d;

  always_comb begin
    n1_d        = {s6_mag_q, 24'(beta_eff >> 1)};
    side1_d.oor = s6_oor_q;
    side1_d.neg = s6_neg_q;
    side1_d.ovf = BETA_W'(n1_d[N1_W-1:TERM_W]) >= beta_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else if (en) s7_v_q <= s6_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_n1_q   <= n1_d;
      s7_b_q    <= beta_eff;
      s7_side_q <= side1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: ln ratio term in Q48
  logic                 d1_v;
  logic [TERM_W-1:0]    d1_term;
  logic [$bits(div1_side_t)-1:0] d1_side_raw;
  div1_side_t           d1_side;

  tcf_div_pipe #(
    .NW (N1_W),
    .DW (BETA_W),
    .QW (TERM_W),
    .SW ($bits(div1_side_t))
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .num_i   (s7_n1_q),
    .den_i   (s7_b_q),
    .side_i  (s7_side_q),
    .valid_o (d1_v),
    .quo_o   (d1_term),
    .side_o  (d1_side_raw)
  );

  assign d1_side = div1_side_t'(d1_side_raw);

  // --------------------------------------------------------------------------
  // S8: inverse temperature
  logic                    s8_v_q;
  logic signed [INV_W-1:0] s8_inv_q;
  div1_side_t              s8_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_v_q <= 1'b0;
    else if (en) s8_v_q <= d1_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_side_q <= d1_side;
      s8_inv_q  <= d1_side.neg ? $signed(INV_T0 - INV_W'(d1_term))
                               : $signed(INV_T0 + INV_W'(d1_term));
    end
  end

  // --------------------------------------------------------------------------
  // S9: reciprocal operands and saturation classes
  logic            s9_v_q;
  logic [N2_W-1:0] s9_n2_q, n2_d;
  logic [D2_W-1:0] s9_d2_q, d2_d;
  div2_side_t      s9_side_q, side2_d;
  logic [U_W-1:0]  u_d;
  logic            inv_neg, inv_zero, ovf2;

  always_comb begin
    u_d      = s8_inv_q[U_W-1:0];
    inv_neg  = s8_inv_q[INV_W-1];
    inv_zero = (s8_inv_q == '0);
    n2_d     = NUM_360 + N2_W'(u_d);
    d2_d     = {u_d, 1'b0};
    ovf2     = D2_W'(n2_d[N2_W-1:Q2_W]) >= d2_d;
    side2_d.oor    = s8_side_q.oor;
    side2_d.sat_lo = s8_side_q.ovf || inv_neg;
    side2_d.sat_hi = !s8_side_q.ovf && !inv_neg && (inv_zero || ovf2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s9_v_q <= 1'b0;
    else if (en) s9_v_q <= s8_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_n2_q   <= n2_d;
      s9_d2_q   <= d2_d;
      s9_side_q <= side2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: rounded 180*2^48 / inv
  logic                          d2_v;
  logic [Q2_W-1:0]               d2_q;
  logic [$bits(div2_side_t)-1:0] d2_side_raw;
  div2_side_t                    d2_side;

  tcf_div_pipe #(
    .NW (N2_W),
    .DW (D2_W),
    .QW (Q2_W),
    .SW ($bits(div2_side_t))
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_v_q),
    .num_i   (s9_n2_q),
    .den_i   (s9_d2_q),
    .side_i  (s9_side_q),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .side_o  (d2_side_raw)
  );

  assign d2_side = div2_side_t'(d2_side_raw);

  // --------------------------------------------------------------------------
  // Final offset, clamp and status
  logic signed [TMP_W-1:0]  tmp_d;
  logic signed [TEMP_W-1:0] res_temp;
  logic [STATUS_W-1:0]      res_status;

  always_comb begin
    tmp_d = $signed(TMP_W'(d2_q)) - TEMP_OFFSET;
    if (d2_side.oor) begin
      res_temp   = '0;
      res_status = STATUS_RANGE;
    end else if (d2_side.sat_lo) begin
      res_temp   = TEMP_W'(TEMP_MIN);
      res_status = STATUS_SAT;
    end else if (d2_side.sat_hi || (tmp_d > TEMP_MAX)) begin
      res_temp   = TEMP_W'(TEMP_MAX);
      res_status = STATUS_SAT;
    end else if (tmp_d < TEMP_MIN) begin
      res_temp   = TEMP_W'(TEMP_MIN);
      res_status = STATUS_SAT;
    end else begin
      res_temp   = tmp_d[TEMP_W-1:0];
      res_status = STATUS_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer
  logic                     push, pop;
  logic [1:0]               ocnt_d;
  logic signed [TEMP_W-1:0] ot0_q, ot1_q;
  logic [STATUS_W-1:0]      os0_q, os1_q;

  assign push   = en && d2_v;
  assign pop    = out_valid_o && out_ready_i;
  assign ocnt_d = ocnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ocnt_q <= 2'd0;
    else         ocnt_q <= ocnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (ocnt_q == 2'd2) begin
        ot0_q <= ot1_q;
        os0_q <= os1_q;
      end else if (push) begin
        ot0_q <= res_temp;
        os0_q <= res_status;
      end
    end else if (push) begin
      if (ocnt_q == 2'd0) begin
        ot0_q <= res_temp;
        os0_q <= res_status;
      end else begin
        ot1_q <= res_temp;
        os1_q <= res_status;
      end
    end
  end

  assign out_valid_o    = (ocnt_q != 2'd0);
  assign temp_centi_f_o = ot0_q;
  assign status_o       = os0_q;

endmodule

`default_nettype wire
